>>> rtl/core/assert_macros.svh
// assertion macros for the rtl of the heading framer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> rtl/core/hpcf_pkg.sv
// constants shared by the heading p-control framer
`timescale 1ns / 1ps

package hpcf_pkg;

	// heading wrap
	localparam int HALF_TURN      = 180;
	localparam int FULL_TURN      = 360;
	// bias that moves an angle above the half turn onto a zero base
	localparam int WRAP_HI_BIAS   = HALF_TURN + 1;
	// bias that moves an angle below minus half turn onto a positive base (91 turns)
	localparam int WRAP_LO_BIAS   = HALF_TURN + 91 * FULL_TURN;
	// ceil(2^24 / 360), exact floor quotient for 15-bit dividends
	localparam int RECIP_SHIFT    = 24;
	localparam int RECIP_TURN     = 46604;
	localparam int WRAP_W         = 15;
	localparam int QUOT_W         = 7;

	localparam int SPEED_W        = 8;
	localparam int SPEED_LIMIT    = 255;
	localparam int GAIN_W         = 16;
	localparam int ANGLE_W        = 16;

	// decimal split
	localparam int TEN_RECIP      = 103;
	localparam int TEN_SHIFT      = 10;

	// configuration registers
	localparam int REG_IDX_W      = 1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN = 1'b0;
	localparam logic [15:0] GAIN_RESET = 16'd512;

	// frame layout
	localparam int FRAME_LEN      = 17;
	localparam int BIDX_W         = $clog2(FRAME_LEN);
	localparam logic [BIDX_W-1:0] POS_START  = BIDX_W'(0);
	localparam logic [BIDX_W-1:0] POS_ADDR   = BIDX_W'(1);
	localparam logic [BIDX_W-1:0] POS_RSIGN  = BIDX_W'(2);
	localparam logic [BIDX_W-1:0] POS_R2     = BIDX_W'(4);
	localparam logic [BIDX_W-1:0] POS_R1     = BIDX_W'(6);
	localparam logic [BIDX_W-1:0] POS_R0     = BIDX_W'(8);
	localparam logic [BIDX_W-1:0] POS_LSIGN  = BIDX_W'(10);
	localparam logic [BIDX_W-1:0] POS_L2     = BIDX_W'(12);
	localparam logic [BIDX_W-1:0] POS_L1     = BIDX_W'(14);
	localparam logic [BIDX_W-1:0] POS_L0     = BIDX_W'(16);
	localparam logic [BIDX_W-1:0] POS_LAST   = BIDX_W'(FRAME_LEN - 1);

	// ascii codes
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;

endpackage

>>> rtl/core/heading_p_control_framer.sv
// heading p-control framer: wrap, gain, saturate and ascii frame serializer
`timescale 1ns / 1ps

// channel   | dir | signals                              | payload
// s_axis    | in  | s_axis_tvalid/tready/tdata[15:0]     | angle_deg (signed degrees)
// m_axis    | out | m_axis_tvalid/tready/tdata[7:0]/tlast | frame_byte, tlast = last_byte
// apb       | in  | psel/penable/pwrite/paddr/pwdata     | gain_q8_8 at address 0
//
// each accepted angle yields one 17-byte frame, one byte per cycle while m_axis
// does not stall; the byte serializer steps through the frame byte by byte
// a transfer passes stages 1 to 6 and the frame register before its first byte
// the six-stage front end keeps accepting angles while a frame is still going out
// reset clears all valid flags and the byte index and loads the gain with 2.0
// a stalled m_axis holds the current byte and the front end fills up behind it

module heading_p_control_framer
	import hpcf_pkg::*;
#(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] angle_deg
	// master stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
	output logic        m_axis_tlast,   // last_byte
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PROD_W = SPEED_W + GAIN_W;

	// ---------------- configuration ----------------
	logic [GAIN_W-1:0] gain_q;
	logic              cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_wr && reg_idx == REG_GAIN) begin
			gain_q <= pwdata[GAIN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_GAIN) begin
			prdata = {{(32-GAIN_W){1'b0}}, gain_q};
		end
	end

	// ---------------- pipeline control ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, frm_v_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_frm;
	logic byte_xfer, frame_done;
	logic [BIDX_W-1:0] byte_idx_q;

	assign byte_xfer  = m_axis_tvalid && m_axis_tready;
	assign frame_done = byte_xfer && (byte_idx_q == POS_LAST);

	// each stage loads when empty or when its content moves on
	assign rdy_frm = !frm_v_q || frame_done;
	assign rdy_s6  = !v_s6 || rdy_frm;
	assign rdy_s5  = !v_s5 || rdy_s6;
	assign rdy_s4  = !v_s4 || rdy_s5;
	assign rdy_s3  = !v_s3 || rdy_s4;
	assign rdy_s2  = !v_s2 || rdy_s3;
	assign rdy_s1  = !v_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			frm_v_q <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1    <= s_axis_tvalid;
			if (rdy_s2)  v_s2    <= v_s1;
			if (rdy_s3)  v_s3    <= v_s2;
			if (rdy_s4)  v_s4    <= v_s3;
			if (rdy_s5)  v_s5    <= v_s4;
			if (rdy_s6)  v_s6    <= v_s5;
			if (rdy_frm) frm_v_q <= v_s6;
		end
	end

	// ---------------- stage 1: input register ----------------
	logic signed [ANGLE_W-1:0] angle_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			angle_s1 <= s_axis_tdata;
		end
	end

	// ---------------- stage 2: classify and rebase ----------------
	// angles outside -180..180 move onto a non-negative base for the mod 360
	logic signed [ANGLE_W:0] angle_x;
	logic signed [ANGLE_W:0] base_x;
	logic                    hi_c, lo_c;
	logic [WRAP_W-1:0]       y_s2;
	logic                    hi_s2, lo_s2;
	logic signed [8:0]       small_s2;

	always_comb begin
		angle_x = {angle_s1[ANGLE_W-1], angle_s1};
		hi_c    = angle_x > (ANGLE_W+1)'(HALF_TURN);
		lo_c    = angle_x < -(ANGLE_W+1)'(HALF_TURN);
		if (hi_c) begin
			base_x = angle_x - (ANGLE_W+1)'(WRAP_HI_BIAS);
		end else begin
			base_x = angle_x + (ANGLE_W+1)'(WRAP_LO_BIAS);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			y_s2     <= base_x[WRAP_W-1:0];
			hi_s2    <= hi_c;
			lo_s2    <= lo_c;
			small_s2 <= angle_s1[8:0];
		end
	end

	// ---------------- stage 3: quotient by reciprocal ----------------
	logic [WRAP_W+RECIP_SHIFT-1:0] quot_full;
	logic [QUOT_W-1:0]             q_s3;
	logic [WRAP_W-1:0]             y_s3;
	logic                          hi_s3, lo_s3;
	logic signed [8:0]             small_s3;

	assign quot_full = (WRAP_W+RECIP_SHIFT)'(y_s2) * (WRAP_W+RECIP_SHIFT)'(RECIP_TURN);

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			q_s3     <= quot_full[RECIP_SHIFT +: QUOT_W];
			y_s3     <= y_s2;
			hi_s3    <= hi_s2;
			lo_s3    <= lo_s2;
			small_s3 <= small_s2;
		end
	end

	// ---------------- stage 4: remainder and wrapped error ----------------
	logic [WRAP_W-1:0]   turns;
	logic [WRAP_W-1:0]   rem_full;
	logic signed [9:0]   err_c;
	logic [SPEED_W-1:0]  abs_s4;
	logic                neg_s4, pos_s4;

	always_comb begin
		turns    = WRAP_W'(q_s3) * WRAP_W'(FULL_TURN);
		rem_full = y_s3 - turns;
		if (hi_s3) begin
			err_c = $signed({1'b0, rem_full[8:0]}) - 10'sd179;
		end else if (lo_s3) begin
			err_c = $signed({1'b0, rem_full[8:0]}) - 10'sd180;
		end else begin
			err_c = {small_s3[8], small_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			abs_s4 <= err_c[9] ? SPEED_W'(-err_c) : SPEED_W'(err_c);
			neg_s4 <= err_c[9];
			pos_s4 <= !err_c[9] && (err_c != '0);
		end
	end

	// ---------------- stage 5: gain product ----------------
	logic [PROD_W-1:0] prod_s5;
	logic              neg_s5, pos_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			prod_s5 <= PROD_W'(abs_s4) * PROD_W'(gain_q);
			neg_s5  <= neg_s4;
			pos_s5  <= pos_s4;
		end
	end

	// ---------------- stage 6: truncate, saturate, signs ----------------
	logic [PROD_W-1:0]  shifted;
	logic [SPEED_W-1:0] mag_c;
	logic [SPEED_W-1:0] mag_s6;
	logic               rneg_s6, lneg_s6;

	always_comb begin
		shifted = prod_s5 >> GAIN_FRAC_BITS;
		if (|shifted[PROD_W-1:SPEED_W]) begin
			mag_c = SPEED_W'(SPEED_LIMIT);
		end else begin
			mag_c = shifted[SPEED_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			mag_s6  <= mag_c;
			rneg_s6 <= neg_s5 && (mag_c != '0);
			lneg_s6 <= pos_s5 && (mag_c != '0);
		end
	end

	// ---------------- frame register: decimal digits ----------------
	logic [1:0]  d2_c;
	logic [6:0]  rem100;
	logic [13:0] tens_full;
	logic [3:0]  d1_c;
	logic [3:0]  d0_c;
	logic [3:0]  d2_q, d1_q, d0_q;
	logic        rneg_q, lneg_q;

	always_comb begin
		if (mag_s6 >= 8'd200) begin
			d2_c = 2'd2;
		end else if (mag_s6 >= 8'd100) begin
			d2_c = 2'd1;
		end else begin
			d2_c = 2'd0;
		end
		rem100    = 7'(mag_s6 - 8'(d2_c) * 8'd100);
		tens_full = 14'(rem100) * 14'(TEN_RECIP);
		d1_c      = tens_full[TEN_SHIFT +: 4];
		d0_c      = 4'(rem100 - 7'(d1_c) * 7'd10);
	end

	always_ff @(posedge clk) begin
		if (rdy_frm) begin
			d2_q   <= {2'b00, d2_c};
			d1_q   <= d1_c;
			d0_q   <= d0_c;
			rneg_q <= rneg_s6;
			lneg_q <= lneg_s6;
		end
	end

	// ---------------- byte serializer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
		end else if (frame_done) begin
			byte_idx_q <= '0;
		end else if (byte_xfer) begin
			byte_idx_q <= byte_idx_q + BIDX_W'(1);
		end
	end

	assign m_axis_tvalid = frm_v_q;
	assign m_axis_tlast  = (byte_idx_q == POS_LAST);

	always_comb begin
		unique case (byte_idx_q)
			POS_START:            m_axis_tdata = CH_HASH;
			POS_ADDR:             m_axis_tdata = CH_A;
			POS_RSIGN:            m_axis_tdata = rneg_q ? CH_MINUS : CH_PLUS;
			POS_LSIGN:            m_axis_tdata = lneg_q ? CH_MINUS : CH_PLUS;
			POS_R2, POS_L2:       m_axis_tdata = CH_ZERO + {4'b0000, d2_q};
			POS_R1, POS_L1:       m_axis_tdata = CH_ZERO + {4'b0000, d1_q};
			POS_R0, POS_L0:       m_axis_tdata = CH_ZERO + {4'b0000, d0_q};
			default:              m_axis_tdata = CH_C;
		endcase
	end

	// ---------------- assertions ----------------
	`include "assert_macros.svh"

	`ASSERT_CLK(a_idx_wraps, frame_done |=> (byte_idx_q == POS_START), "byte index not back at start")
	`ASSERT_CLK(a_digits_ok, frm_v_q |-> (d2_q <= 4'd2 && d1_q <= 4'd9 && d0_q <= 4'd9), "bad digit")
	`ASSERT_CLK(a_zero_plus, (frm_v_q && d2_q == '0 && d1_q == '0 && d0_q == '0) |-> (!rneg_q && !lneg_q), "zero speed with minus sign")
	`ASSERT_NEVER(a_sign_excl, frm_v_q && rneg_q && lneg_q, "both wheels negative")
	`ASSERT_CLK(a_stall_idx, (m_axis_tvalid && !m_axis_tready) |=> $stable(byte_idx_q), "byte index moved under stall")

endmodule

>>> dv/testbench.sv
// self-checking testbench for the heading p-control framer: angle stream in, ascii frames out
`timescale 1ns / 1ps

module testbench;
	import hpcf_pkg::*;

	// fraction bits of the gain, passed to the block as well
	localparam int FRAC_BITS = 8;
	// byte addresses of the gain register and of an unused register slot
	localparam logic [2:0] GAIN_ADDR  = 3'd0;
	localparam logic [2:0] SPARE_ADDR = 3'd4;
	// cycles allowed for the front end to settle once the last byte is out
	localparam int SETTLE = 16;
	// hard stop for the whole run
	localparam int CYCLE_LIMIT = 800000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 25;

	// one byte of a command frame as seen on m_axis
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} frame_beat_t;

	// holds the gain copy and the queue of frame bytes still to come
	class frame_scoreboard;
		frame_beat_t beats[$];
		logic [15:0] gain;
		int          errors;

		function new();
			gain = GAIN_RESET;
			errors = 0;
		endfunction

		// register write as the block should see it, other indexes are ignored
		function void note_write(logic [2:0] addr, logic [31:0] data);
			if (addr[REG_IDX_W+1:2] == REG_GAIN)
				gain = data[15:0];
		endfunction

		// fold an angle into -180..180, both ends kept
		function int wrap_heading(int a);
			int m;
			if (a > HALF_TURN) begin
				m = (a - (HALF_TURN + 1)) % FULL_TURN;
				return m + (HALF_TURN + 1) - FULL_TURN;
			end
			if (a < -HALF_TURN) begin
				m = ((a + HALF_TURN) % FULL_TURN + FULL_TURN) % FULL_TURN;
				return -HALF_TURN + m;
			end
			return a;
		endfunction

		// accepted angle: queue the 17 bytes of its frame
		function void note_angle(logic signed [15:0] angle);
			int          err;
			int unsigned absval;
			int unsigned mag;
			logic        right_neg;
			logic        left_neg;
			logic [7:0]  d2, d1, d0;
			logic [7:0]  frame [FRAME_LEN];
			frame_beat_t beat;
			err = wrap_heading(int'(angle));
			absval = (err < 0) ? int'(-err) : err;
			// truncating product, then saturate
			mag = (absval * int'(gain)) >> FRAC_BITS;
			if (mag > SPEED_LIMIT)
				mag = SPEED_LIMIT;
			// a zero speed always carries plus signs
			right_neg = (err < 0) && (mag != 0);
			left_neg = (err > 0) && (mag != 0);
			d2 = CH_ZERO + 8'(mag / 100);
			d1 = CH_ZERO + 8'((mag / 10) % 10);
			d0 = CH_ZERO + 8'(mag % 10);
			for (int k = 0; k < FRAME_LEN; k++)
				frame[k] = CH_C;
			frame[POS_START] = CH_HASH;
			frame[POS_ADDR]  = CH_A;
			frame[POS_RSIGN] = right_neg ? CH_MINUS : CH_PLUS;
			frame[POS_R2]    = d2;
			frame[POS_R1]    = d1;
			frame[POS_R0]    = d0;
			frame[POS_LSIGN] = left_neg ? CH_MINUS : CH_PLUS;
			frame[POS_L2]    = d2;
			frame[POS_L1]    = d1;
			frame[POS_L0]    = d0;
			for (int k = 0; k < FRAME_LEN; k++) begin
				beat.frame_byte = frame[k];
				beat.last_byte = (k == FRAME_LEN - 1);
				beats.push_back(beat);
			end
		endfunction

		// compare one byte transfer against the oldest queued byte
		function void check_beat(logic [7:0] data, logic last);
			frame_beat_t want;
			if (beats.size() == 0) begin
				$error("unexpected frame byte %h last %b", data, last);
				errors++;
				return;
			end
			want = beats.pop_front();
			if (data !== want.frame_byte) begin
				$error("frame_byte: expected %h, actual %h", want.frame_byte, data);
				errors++;
			end
			if (last !== want.last_byte) begin
				$error("last_byte: expected %b, actual %b", want.last_byte, last);
				errors++;
			end
		endfunction

		function int pending();
			return beats.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	frame_scoreboard frames = new();
	int          cycle_count = 0;
	// no random gaps on either side while set
	bit          steady = 1'b0;
	int          stall_left = 0;

	heading_p_control_framer #(
		.GAIN_FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (steady || r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver side: random stall runs on m_axis_tready
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (arst_n && !steady && $urandom_range(0, 3) == 0) begin
			stall_left <= pick_gap();
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// every byte transfer on m_axis goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			frames.check_beat(m_axis_tdata, m_axis_tlast);
	end

	// runaway guard
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("heading_p_control_framer regression: fail");
		$finish;
	end

	// present one angle, hold it until the transfer, then an optional gap
	task automatic send_angle(logic [15:0] angle);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= angle;
		do
			@(posedge clk);
		while (!s_axis_tready);
		frames.note_angle(angle);
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid and wait until every queued frame byte has come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (frames.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// apb write after a drain: setup cycle, then access until pready
	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		frames.note_write(addr, data);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// mix of in-range angles, wrap boundaries, near zero and full range
	function automatic logic [15:0] pick_angle();
		int r;
		int a;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			a = int'($urandom_range(0, 400)) - 200;
		end else if (r < 7) begin
			return 16'($urandom());
		end else if (r < 9) begin
			// odd multiples of a half turn, one either side
			a = HALF_TURN + FULL_TURN * int'($urandom_range(0, 90))
				+ int'($urandom_range(0, 2)) - 1;
			if ($urandom_range(0, 1))
				a = -a;
		end else begin
			a = int'($urandom_range(0, 6)) - 3;
		end
		return 16'(a);
	endfunction

	function automatic logic [31:0] pick_gain_word();
		logic [15:0] g;
		case ($urandom_range(0, 3))
			0: begin
				g = 16'($urandom_range(1, 700));
			end
			1: begin
				g = 16'($urandom());
			end
			2: begin
				g = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			end
			default: begin
				g = 16'($urandom_range(200, 400));
			end
		endcase
		// upper bits are don't care for a 16-bit register
		return {16'($urandom()), g};
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// reset gain of 2.0: zero, unit steps, both wrap ends, the extremes
		send_angle(16'sd0);
		send_angle(16'sd1);
		send_angle(-16'sd1);
		send_angle(16'sd180);
		send_angle(-16'sd180);
		send_angle(16'sd181);
		send_angle(-16'sd181);
		send_angle(16'sd32767);
		send_angle(-16'sd32768);
		send_angle(16'sd360);
		send_angle(-16'sd360);
		send_angle(16'sd539);
		send_angle(-16'sd539);

		// largest gain saturates anything but zero
		apb_write(GAIN_ADDR, 32'hFFFF_FFFF);
		send_angle(16'sd1);
		send_angle(-16'sd1);
		send_angle(16'sd0);
		send_angle(16'sd90);

		// zero gain: zero speed with either sign of error
		apb_write(GAIN_ADDR, 32'h0000_0000);
		send_angle(16'sd100);
		send_angle(-16'sd100);

		// tiny gain truncates to zero
		apb_write(GAIN_ADDR, 32'd1);
		send_angle(16'sd180);
		send_angle(-16'sd179);

		// fractional product below the limit
		apb_write(GAIN_ADDR, 32'd300);
		send_angle(16'sd179);
		send_angle(-16'sd179);

		// write to an unused index leaves the gain alone
		apb_write(SPARE_ADDR, 32'h0000_0000);
		send_angle(16'sd100);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			// some phases run with no gaps to keep the front end full
			steady = (p % 3 == 1);
			if ($urandom_range(0, 3) == 0)
				apb_write(SPARE_ADDR, $urandom());
			apb_write(GAIN_ADDR, pick_gain_word());
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_angle(pick_angle());
			drain();
		end
		steady = 1'b0;

		if (frames.errors == 0 && frames.pending() == 0) begin
			$display("heading_p_control_framer regression: pass");
		end else begin
			$display("heading_p_control_framer regression: fail");
		end
		$finish;
	end

endmodule
